// File: rtl/abkf_pkg.sv
// ----------------------------------------------------------------------------
// abkf_pkg: shared types, constants and helper functions
// Fixed-point format, register indexes, datapath ops, channel words and saturation helpers.
// ----------------------------------------------------------------------------
package abkf_pkg;

	localparam int FRAC_BITS = 16;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_INITIAL_BIAS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GYRO_SCALE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MEASURE_NS   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_NS     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BIAS_NS      = 3'd5;

	// shared unit operations
	localparam int OP_W = 2;
	localparam logic [OP_W-1:0] OP_ADD = 2'd0;
	localparam logic [OP_W-1:0] OP_SUB = 2'd1;
	localparam logic [OP_W-1:0] OP_MUL = 2'd2;
	localparam logic [OP_W-1:0] OP_DIV = 2'd3;

	// channel words
	typedef struct packed {
		logic signed [15:0] gyro_rate;
		logic signed [31:0] accel_angle;
	} imu_word_t;

	typedef struct packed {
		logic signed [31:0] angle_estimate;
	} angle_word_t;

	typedef struct packed {
		logic             start;
		logic [OP_W-1:0]  op;
		logic signed [31:0] a;
		logic signed [31:0] b;
	} alu_req_t;

	typedef struct packed {
		logic               done;
		logic signed [31:0] res;
	} alu_rsp_t;

	// saturate a 34-bit sum to 32 bits
	function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
		if (v > 34'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
		if (v < -34'sh0_8000_0000) return 32'sh8000_0000;
		return v[31:0];
	endfunction

	// saturate a 48-bit value to 32 bits
	function automatic logic signed [31:0] sat48(input logic signed [47:0] v);
		if (v > 48'sh0000_7FFF_FFFF) return 32'sh7FFF_FFFF;
		if (v < -48'sh0000_8000_0000) return 32'sh8000_0000;
		return v[31:0];
	endfunction

endpackage

// File: rtl/abkf_if.sv
// ----------------------------------------------------------------------------
// abkf_if: valid/ready channel
// Carries one word of the given payload type.
// ----------------------------------------------------------------------------
interface abkf_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/abkf_alu.sv
// ----------------------------------------------------------------------------
// abkf_alu: shared saturating arithmetic unit
// Add/sub registered at once, multiply through a product register, restoring divide one bit a cycle.
// ----------------------------------------------------------------------------
module abkf_alu (
	input  logic              clk,
	input  logic              arst_n,
	input  abkf_pkg::alu_req_t req,
	output abkf_pkg::alu_rsp_t rsp
);
	import abkf_pkg::*;

	localparam int NW = 32 + FRAC_BITS;  // scaled numerator bits
	localparam int QW = NW + 1;          // quotient bits worth computing

	logic [1:0]         mode_q;   // 0 idle, 1 mul, 2 div, 3 div finish
	logic signed [63:0] prod_q;
	logic [NW-1:0]      num_q;
	logic [31:0]        den_q;
	logic [32:0]        rem_q;
	logic [QW-1:0]      quo_q;
	logic [5:0]         cnt_q;
	logic               neg_q;
	logic signed [31:0] res_q;
	logic               done_q;

	logic [33:0] trial;
	logic [32:0] shifted;
	logic [63:0] rnd;
	logic signed [63:0] rq;
	logic signed [QW:0] sq;

	assign shifted = {rem_q[31:0], num_q[NW-1]};
	assign trial   = {1'b0, shifted} - {2'b0, den_q};
	assign rnd     = prod_q + (64'sd1 <<< (FRAC_BITS - 1));
	assign rq      = $signed(rnd) >>> FRAC_BITS;
	assign sq      = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 2'd0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				case (req.op)
					OP_ADD: begin
						res_q  <= sat34(34'(req.a) + 34'(req.b));
						done_q <= 1'b1;
					end
					OP_SUB: begin
						res_q  <= sat34(34'(req.a) - 34'(req.b));
						done_q <= 1'b1;
					end
					OP_MUL: begin
						prod_q <= 64'(req.a) * 64'(req.b);
						mode_q <= 2'd1;
					end
					default: begin
						// a / max(b,1), magnitude restoring division
						num_q  <= {(req.a[31] ? 32'(-req.a) : 32'(req.a)), {FRAC_BITS{1'b0}}};
						den_q  <= (req.b < 32'sd1) ? 32'd1 : 32'(req.b);
						neg_q  <= req.a[31];
						rem_q  <= '0;
						quo_q  <= '0;
						cnt_q  <= 6'(NW);
						mode_q <= 2'd2;
					end
				endcase
			end else if (mode_q == 2'd1) begin
				res_q  <= (rq > 64'sh7FFF_FFFF) ? 32'sh7FFF_FFFF :
					(rq < -64'sh8000_0000) ? 32'sh8000_0000 : rq[31:0];
				done_q <= 1'b1;
				mode_q <= 2'd0;
			end else if (mode_q == 2'd2) begin
				// one quotient bit per cycle
				num_q <= {num_q[NW-2:0], 1'b0};
				if (!trial[33]) begin
					rem_q <= trial[32:0];
					quo_q <= {quo_q[QW-2:0], 1'b1};
				end else begin
					rem_q <= shifted;
					quo_q <= {quo_q[QW-2:0], 1'b0};
				end
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) mode_q <= 2'd3;
			end else if (mode_q == 2'd3) begin
				res_q  <= (sq > $signed({2'b0, 31'h7FFF_FFFF})) ? 32'sh7FFF_FFFF :
					(sq < -$signed({2'b0, 32'h8000_0000})) ? 32'sh8000_0000 : sq[31:0];
				done_q <= 1'b1;
				mode_q <= 2'd0;
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.res  = res_q;

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == 2'd2 |-> cnt_q != 6'd0) else $error("divider count ran out");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q || $past(req.start)) else $error("done held");
	a_idle_done: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == 2'd1) |=> done_q) else $error("multiply not done");
endmodule

// File: rtl/angle_bias_kalman_filter_unit.sv
// Operation: the sequencer steps the shared unit through 29 ops, one at a time:
// 16 add/sub, 11 multiplies and 2 divides of 48 quotient bits each.
// Ready is low while a word is at work; a new word is taken only once the last
// is done, a finished word waits in the output register and only the last op stalls.
// Reset: async active low; angle and covariance zero, bias and registers to defaults.
// ----------------------------------------------------------------------------
// angle_bias_kalman_filter_unit: two-state angle/bias Kalman filter
// Sequencer driving one shared saturating add/multiply/divide unit.
// ----------------------------------------------------------------------------
module angle_bias_kalman_filter_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [abkf_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [31:0] cfg_wdata,
	abkf_if.sink        in_ch,
	abkf_if.source      out_ch
);
	import abkf_pkg::*;

	localparam int PC_W = 6;
	localparam logic [PC_W-1:0] LAST_STEP = 6'd28;
	localparam logic [PC_W-1:0] N_STEPS = 6'd29;

	// config
	logic [15:0] dt_q;
	logic [30:0] scale_q, rn_q, qa_q, qg_q;
	// state
	logic signed [31:0] ang_q, bias_q, p00_q, p01_q, p10_q, p11_q;
	// temporaries
	logic signed [31:0] gyro_q, acc_q, t0_q, t1_q, err_q, e_q, g0_q, g1_q;
	logic signed [31:0] r_q;
	logic busy_q, wait_q, ovalid_q;
	logic [PC_W-1:0] pc_q;
	logic signed [31:0] res_q;

	alu_req_t req;
	alu_rsp_t rsp;
	logic signed [31:0] dt_s, sc_s;
	logic signed [47:0] gyro_w;

	assign dt_s = 32'({16'd0, dt_q});
	assign sc_s = 32'({1'b0, scale_q});

	// raw gyro counts to fixed point
	assign gyro_w = 48'(in_ch.data.gyro_rate) <<< FRAC_BITS;

	abkf_alu u_alu (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	// operation program: ops and operands per step
	always_comb begin
		req.start = busy_q && !wait_q && !(pc_q == LAST_STEP && ovalid_q);
		req.op = OP_ADD;
		req.a = '0;
		req.b = '0;
		case (pc_q)
			6'd0:  begin req.op = OP_SUB; req.a = bias_q; req.b = gyro_q; end
			6'd1:  begin req.op = OP_MUL; req.a = r_q; req.b = dt_s; end
			6'd2:  begin req.op = OP_MUL; req.a = r_q; req.b = sc_s; end
			6'd3:  begin req.op = OP_SUB; req.a = ang_q; req.b = r_q; end
			6'd4:  begin req.op = OP_SUB; req.a = acc_q; req.b = r_q; end
			6'd5:  begin req.op = OP_ADD; req.a = p00_q; req.b = 32'({1'b0, rn_q}); end
			6'd6:  begin req.op = OP_MUL; req.a = p00_q; req.b = dt_s; end
			6'd7:  begin req.op = OP_DIV; req.a = r_q; req.b = e_q; end
			6'd8:  begin req.op = OP_DIV; req.a = p10_q; req.b = e_q; end
			6'd9:  begin req.op = OP_MUL; req.a = g0_q; req.b = err_q; end
			6'd10: begin req.op = OP_ADD; req.a = ang_q; req.b = r_q; end
			6'd11: begin req.op = OP_MUL; req.a = g1_q; req.b = err_q; end
			6'd12: begin req.op = OP_ADD; req.a = bias_q; req.b = r_q; end
			// P00
			6'd13: begin req.op = OP_ADD; req.a = p01_q; req.b = p10_q; end
			6'd14: begin req.op = OP_MUL; req.a = dt_s; req.b = r_q; end
			6'd15: begin req.op = OP_SUB; req.a = p00_q; req.b = r_q; end
			6'd16: begin req.op = OP_MUL; req.a = g0_q; req.b = p00_q; end
			6'd17: begin req.op = OP_SUB; req.a = t0_q; req.b = r_q; end
			6'd18: begin req.op = OP_ADD; req.a = r_q; req.b = 32'({1'b0, qa_q}); end
			// P01
			6'd19: begin req.op = OP_MUL; req.a = dt_s; req.b = p11_q; end
			6'd20: begin req.op = OP_SUB; req.a = p01_q; req.b = r_q; end
			6'd21: begin req.op = OP_MUL; req.a = g0_q; req.b = p01_q; end
			6'd22: begin req.op = OP_SUB; req.a = t0_q; req.b = r_q; end
			// P10 (t1 holds dt*p11)
			6'd23: begin req.op = OP_SUB; req.a = p10_q; req.b = t1_q; end
			6'd24: begin req.op = OP_MUL; req.a = g1_q; req.b = p00_q; end
			6'd25: begin req.op = OP_SUB; req.a = t0_q; req.b = r_q; end
			// P11
			6'd26: begin req.op = OP_MUL; req.a = g1_q; req.b = p01_q; end
			6'd27: begin req.op = OP_SUB; req.a = p11_q; req.b = r_q; end
			6'd28: begin req.op = OP_ADD; req.a = r_q; req.b = 32'({1'b0, qg_q}); end
			default: req.start = 1'b0;
		endcase
	end

	assign in_ch.ready   = !busy_q;
	assign out_ch.valid  = ovalid_q;
	assign out_ch.data   = res_q;

	// sequencer and result capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q <= 16'd655; scale_q <= 31'd65536;
			rn_q <= 31'd19661; qa_q <= 31'd66; qg_q <= 31'd197;
			ang_q <= '0; bias_q <= '0;
			p00_q <= '0; p01_q <= '0; p10_q <= '0; p11_q <= '0;
			busy_q <= 1'b0; wait_q <= 1'b0; ovalid_q <= 1'b0; pc_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_INITIAL_BIAS: bias_q <= cfg_wdata;
					REG_TIME_STEP:    dt_q <= cfg_wdata[15:0];
					REG_GYRO_SCALE:   scale_q <= cfg_wdata[30:0];
					REG_MEASURE_NS:   rn_q <= cfg_wdata[30:0];
					REG_ANGLE_NS:     qa_q <= cfg_wdata[30:0];
					REG_BIAS_NS:      qg_q <= cfg_wdata[30:0];
					default: ;
				endcase
			end
			if (out_ch.valid && out_ch.ready) ovalid_q <= 1'b0;
			if (in_ch.valid && in_ch.ready) begin
				gyro_q <= sat48(gyro_w);
				acc_q  <= in_ch.data.accel_angle;
				busy_q <= 1'b1;
				pc_q   <= '0;
			end
			if (req.start) wait_q <= 1'b1;
			if (rsp.done) begin
				wait_q <= 1'b0;
				r_q    <= rsp.res;
				pc_q   <= pc_q + 6'd1;
				case (pc_q)
					6'd3:  ang_q <= rsp.res;
					6'd4:  err_q <= rsp.res;
					6'd5:  e_q <= rsp.res;
					6'd7:  g0_q <= rsp.res;
					6'd8:  g1_q <= rsp.res;
					6'd10: ang_q <= rsp.res;
					6'd12: bias_q <= rsp.res;
					6'd15: t0_q <= rsp.res;
					6'd17: t0_q <= rsp.res;
					6'd18: p00_q <= rsp.res;
					6'd19: t1_q <= rsp.res;
					6'd20: t0_q <= rsp.res;
					6'd22: p01_q <= rsp.res;
					6'd23: t0_q <= rsp.res;
					6'd25: p10_q <= rsp.res;
					6'd28: begin
						p11_q    <= rsp.res;
						busy_q   <= 1'b0;
						ovalid_q <= 1'b1;
						res_q    <= ang_q;
					end
					default: ;
				endcase
			end
		end
	end

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !in_ch.ready) else $error("accepted while busy");
	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> pc_q < N_STEPS) else $error("sequencer out of range");
	a_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		wait_q |-> !req.start) else $error("issued while unit busy");
endmodule

// File: dv/angle_bias_kalman_filter_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// angle_bias_kalman_filter_unit_tb: self-checking bench for the angle filter
// Drives gyro/accel words through random idling and a long output hold-off,
// predicts every filtered angle in fixed point and compares it word by word.
// ----------------------------------------------------------------------------
module angle_bias_kalman_filter_unit_tb;
	import abkf_pkg::*;

	localparam int STALL_LIMIT = 5000;
	localparam int HOLD_CYCLES = 400;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [31:0] cfg_wdata;

	abkf_if #(.T(imu_word_t))   in_ch ();
	abkf_if #(.T(angle_word_t)) out_ch ();

	angle_bias_kalman_filter_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source)
	);

	// filter model state and registers
	int          m_dt;
	int          m_scale;
	int          m_noise_r;
	int          m_noise_qa;
	int          m_noise_qg;
	int          m_angle;
	int          m_bias;
	int          m_p00, m_p01, m_p10, m_p11;

	imu_word_t   imu_pending[$];
	int          angle_expected[$];
	int          fail_count;
	int          idle_mode;
	bit          hold_req;
	int          stall_cycles;
	bit          in_taken;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic int sat32(longint v);
		if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
		if (v < -64'sd2147483648) return 32'sh8000_0000;
		return int'(v);
	endfunction

	function automatic int fx_mul(int a, int b);
		longint p;
		p = longint'(a) * longint'(b);
		return sat32((p + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
	endfunction

	function automatic int fx_div(int a, int e);
		longint n;
		n = longint'(a) * (64'sd1 <<< FRAC_BITS);
		if (e < 1) e = 1;
		return sat32(n / longint'(e));
	endfunction

	function automatic int fx_add(int a, int b);
		return sat32(longint'(a) + longint'(b));
	endfunction

	function automatic int fx_sub(int a, int b);
		return sat32(longint'(a) - longint'(b));
	endfunction

	// one filter step, returns the corrected angle
	function automatic int filter_step(imu_word_t w);
		int gyro, err, e, g0, g1, p00, p01, p10, p11;
		gyro = sat32(longint'(w.gyro_rate) * (64'sd1 <<< FRAC_BITS));
		m_angle = fx_sub(m_angle, fx_mul(fx_mul(fx_sub(m_bias, gyro), m_dt), m_scale));
		err = fx_sub(w.accel_angle, m_angle);
		e = fx_add(m_p00, m_noise_r);
		if (e < 1) e = 1;
		g0 = fx_div(fx_mul(m_p00, m_dt), e);
		g1 = fx_div(m_p10, e);
		m_angle = fx_add(m_angle, fx_mul(g0, err));
		m_bias = fx_add(m_bias, fx_mul(g1, err));
		p00 = fx_add(fx_sub(fx_sub(m_p00, fx_mul(m_dt, fx_add(m_p01, m_p10))),
			fx_mul(g0, m_p00)), m_noise_qa);
		p01 = fx_sub(fx_sub(m_p01, fx_mul(m_dt, m_p11)), fx_mul(g0, m_p01));
		p10 = fx_sub(fx_sub(m_p10, fx_mul(m_dt, m_p11)), fx_mul(g1, p00));
		p11 = fx_add(fx_sub(m_p11, fx_mul(g1, p01)), m_noise_qg);
		m_p00 = p00; m_p01 = p01; m_p10 = p10; m_p11 = p11;
		return m_angle;
	endfunction

	// register write, leaves the enable high until cfg_end
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= value;
		case (idx)
			REG_INITIAL_BIAS: m_bias = value;
			REG_TIME_STEP: m_dt = value[15:0];
			REG_GYRO_SCALE: m_scale = value[30:0];
			REG_MEASURE_NS: m_noise_r = value[30:0];
			REG_ANGLE_NS: m_noise_qa = value[30:0];
			REG_BIAS_NS: m_noise_qg = value[30:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic cfg_end();
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic push_word(int gyro, int accel);
		imu_word_t w;
		w.gyro_rate = 16'(gyro);
		w.accel_angle = accel;
		imu_pending.push_back(w);
	endtask

	task automatic push_random(int count);
		int accel;
		repeat (count) begin
			case ($urandom_range(3))
				0: accel = $urandom;
				1: accel = $signed($urandom_range(65536 * 180)) - 65536 * 90;
				2: accel = $signed($urandom_range(4000)) - 2000;
				default: accel = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
			endcase
			push_word($signed(16'($urandom)), accel);
		end
	endtask

	// wait for the block to drain, then let it settle
	task automatic drain();
		while (imu_pending.size() != 0 || angle_expected.size() != 0 || in_ch.valid)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// input driver
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.data <= '0;
		end else if (!in_ch.valid || in_taken) begin
			if (imu_pending.size() != 0 &&
			    !(idle_mode == 0 && $urandom_range(99) < 18) &&
			    !(idle_mode == 1 && $urandom_range(99) < 48)) begin
				in_ch.valid <= 1'b1;
				in_ch.data <= imu_pending.pop_front();
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// output ready, with a long hold-off on request
	int hold_count;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			hold_count <= 0;
		end else if (hold_req && hold_count < HOLD_CYCLES) begin
			out_ch.ready <= 1'b0;
			hold_count <= hold_count + 1;
		end else begin
			if (!hold_req) hold_count <= 0;
			out_ch.ready <= !((idle_mode == 0 && $urandom_range(99) < 48) ||
				(idle_mode == 1 && $urandom_range(99) < 18));
		end
	end

	// sample both channels, predict and check
	always @(posedge clk or negedge arst_n) begin
		int want;
		if (!arst_n) begin
			in_taken <= 1'b0;
			stall_cycles <= 0;
		end else begin
			in_taken <= in_ch.valid && in_ch.ready;
			if (in_ch.valid && in_ch.ready)
				angle_expected.push_back(filter_step(in_ch.data));
			if (out_ch.valid && out_ch.ready) begin
				if (angle_expected.size() == 0) begin
					$error("unexpected word, angle_estimate %0d", out_ch.data.angle_estimate);
					fail_count++;
				end else begin
					want = angle_expected.pop_front();
					if (out_ch.data.angle_estimate !== want) begin
						$error("angle_estimate: expected %0d actual %0d", want,
							out_ch.data.angle_estimate);
						fail_count++;
					end
				end
			end
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin
		fail_count = 0;
		idle_mode = 0;
		hold_req = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		m_dt = 655; m_scale = 65536; m_noise_r = 19661;
		m_noise_qa = 66; m_noise_qg = 197;
		m_angle = 0; m_bias = 0;
		m_p00 = 0; m_p01 = 0; m_p10 = 0; m_p11 = 0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// defaults: field extremes
		push_word(0, 0);
		push_word(32767, 32'sh7FFF_FFFF);
		push_word(-32768, 32'sh8000_0000);
		push_word(-1, 65536);
		push_word(1, -65536);
		push_word(32767, 32'sh8000_0000);
		push_word(-32768, 32'sh7FFF_FFFF);
		push_word(0, 32'sh5555_5555);
		push_word(-21846, 32'shAAAA_AAAA);
		push_word(21845, 0);
		drain();

		// large time step, full scale, zero measurement noise (E clamp)
		write_reg(REG_INITIAL_BIAS, 32'h7FFF_FFFF);
		write_reg(REG_TIME_STEP, 32'h0000_FFFF);
		write_reg(REG_GYRO_SCALE, 32'h7FFF_FFFF);
		write_reg(REG_MEASURE_NS, 32'h0);
		write_reg(REG_ANGLE_NS, 32'h7FFF_FFFF);
		write_reg(REG_BIAS_NS, 32'h7FFF_FFFF);
		cfg_end();
		push_word(-32768, 32'sh8000_0000);
		push_word(32767, 32'sh7FFF_FFFF);
		push_word(0, 0);
		push_random(40);
		hold_req = 1'b1;
		push_random(60);
		drain();
		hold_req = 1'b0;

		// smallest time step, zero scale, minimum bias; unknown indexes ignored
		idle_mode = 1;
		write_reg(REG_INITIAL_BIAS, 32'h8000_0000);
		write_reg(REG_TIME_STEP, 32'h1);
		write_reg(REG_GYRO_SCALE, 32'h0);
		write_reg(REG_MEASURE_NS, 32'h7FFF_FFFF);
		write_reg(REG_ANGLE_NS, 32'h0);
		write_reg(REG_BIAS_NS, 32'h0);
		write_reg(3'd6, 32'hFFFF_FFFF);
		write_reg(3'd7, 32'h1234_5678);
		cfg_end();
		push_word(12, 65536 * 10);
		push_random(120);
		drain();

		// random settings, each register either fully random or a small value
		for (int ph = 0; ph < 4; ph++) begin
			idle_mode = (ph < 1) ? 1 : 2;
			write_reg(REG_INITIAL_BIAS, $urandom_range(1) ? $urandom : $urandom_range(2000));
			write_reg(REG_TIME_STEP, $urandom_range(1) ? $urandom_range(65535, 1)
				: $urandom_range(2000, 1));
			write_reg(REG_GYRO_SCALE, $urandom_range(1) ? $urandom : $urandom_range(131072));
			write_reg(REG_MEASURE_NS, $urandom_range(1) ? $urandom : $urandom_range(40000));
			write_reg(REG_ANGLE_NS, $urandom_range(1) ? $urandom : $urandom_range(500));
			write_reg(REG_BIAS_NS, $urandom_range(1) ? $urandom : $urandom_range(500));
			cfg_end();
			push_random(130);
			drain();
		end

		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// File: angle_bias_kalman_filter_unit.f
rtl/abkf_pkg.sv
rtl/abkf_if.sv
rtl/abkf_alu.sv
rtl/angle_bias_kalman_filter_unit.sv
dv/angle_bias_kalman_filter_unit_tb.sv
